FILE: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)

`define ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

FILE: rtl/ipcs_pkg.sv
// shared widths and types for the inductor phasor companion step block
package ipcs_pkg;

  localparam int COEF_W = 32;
  localparam int OPND_W = 33;
  localparam int PROD_W = COEF_W + OPND_W;
  localparam int FRAC_W = 24;
  localparam int ACC_W  = 48;

  typedef struct packed {
    logic vld;
    logic first;
    logic neg;
  } mac_op_t;

endpackage

FILE: rtl/ipcs_mac.sv
// shared multiply, truncate and accumulate unit
module ipcs_mac import ipcs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_op_t                  op_i,
  input  logic signed [COEF_W-1:0] a_i,
  input  logic signed [OPND_W-1:0] b_i,
  output logic signed [ACC_W-1:0]  acc_o
);

  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0]  term, base, acc_d, acc_q;
  mac_op_t                  op_q;

  assign prod_d = PROD_W'(a_i) * PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= '0;
      acc_q <= '0;
    end else begin
      op_q  <= op_i;
      acc_q <= acc_d;
    end
  end

  // floor by the coefficient fraction bits
  assign term = ACC_W'(prod_q >>> FRAC_W);
  assign base = op_q.first ? '0 : acc_q;

  always_comb begin
    acc_d = acc_q;
    if (op_q.vld) begin
      acc_d = op_q.neg ? (base - term) : (base + term);
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: rtl/inductor_phasor_companion_step_top.sv
// Inductor companion model update for dynamic phasor simulation, top level.
//
// Input channel s_axis: one transaction per time step. tuser is the opcode
// (0 advance, 1 clear). tdata carries the complex terminal voltages in Q16.16.
// Output channel m_axis: one transaction per input, carrying the updated
// branch current and the next equivalent source in Q16.16, saturated.
// Coefficients (Q8.24) and grounding flags are to be written on the cfg port
// only while the block is idle; the block itself does not enforce this.
// An advance runs on the single shared multiply-accumulate unit: eight
// multiplies, with waits where the current must be known before the history
// products start. A clear skips the multiplies and goes straight to the
// finishing step. s_axis is ready again in the same cycle in which the result
// appears, so no new item is accepted before the last one is through its steps.
// A new item is accepted while a result still
// waits; its result is held back until the previous one is taken.
// Reset clears the coefficients, the flags and the stored current and source.
// When m_axis stalls, the finishing step waits and the held result stays put.
`include "assert_macros.svh"

module inductor_phasor_companion_step_top import ipcs_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // vpos_re, vpos_im, vneg_re, vneg_im
  input  logic [127:0]  s_axis_tdata,
  // opcode
  input  logic          s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // current_re, current_im, eq_source_re, eq_source_im
  output logic [127:0]  m_axis_tdata,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [31:0]   cfg_wdata_i
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_RUN  = 1'b1;

  localparam logic [3:0] STP_M0   = 4'd0;
  localparam logic [3:0] STP_M1   = 4'd1;
  localparam logic [3:0] STP_M2   = 4'd2;
  localparam logic [3:0] STP_M3   = 4'd3;
  localparam logic [3:0] STP_GDI  = 4'd5;
  localparam logic [3:0] STP_M4   = 4'd6;
  localparam logic [3:0] STP_M5   = 4'd7;
  localparam logic [3:0] STP_M6   = 4'd8;
  localparam logic [3:0] STP_M7   = 4'd9;
  localparam logic [3:0] STP_LAST = 4'd11;

  localparam logic [2:0] REG_COND_RE = 3'd0;
  localparam logic [2:0] REG_COND_IM = 3'd1;
  localparam logic [2:0] REG_HIST_RE = 3'd2;
  localparam logic [2:0] REG_HIST_IM = 3'd3;
  localparam logic [2:0] REG_POS_GND = 3'd4;
  localparam logic [2:0] REG_NEG_GND = 3'd5;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [31:0] r;
    if ((&x[ACC_W-1:31]) || !(|x[ACC_W-1:31])) begin
      r = x[31:0];
    end else if (x[ACC_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  logic signed [31:0] cond_re_q, cond_im_q, hist_re_q, hist_im_q;
  logic               pos_gnd_q, neg_gnd_q;

  logic [0:0]         st_q, st_d;
  logic [3:0]         cnt_q, cnt_d;
  logic               clr_q;

  logic signed [OPND_W-1:0] dvr_q, dvi_q;
  logic signed [OPND_W-1:0] pr, pi, nr, ni;
  logic signed [ACC_W-1:0]  gdr_q, gdi_q;
  logic signed [31:0]       cr_q, ci_q, sr_q, si;
  logic signed [31:0]       cur_re_q, cur_im_q, es_re_q, es_im_q;
  logic                     m_valid_q;

  mac_op_t                  mac_op;
  logic signed [COEF_W-1:0] mac_a;
  logic signed [OPND_W-1:0] mac_b;
  logic signed [ACC_W-1:0]  acc;

  logic in_acc, slot_free, at_last, commit;

  assign s_axis_tready = (st_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !m_valid_q || m_axis_tready;
  assign at_last       = (st_q == ST_RUN) && (cnt_q == STP_LAST);
  assign commit        = at_last && slot_free;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cond_re_q <= '0;
      cond_im_q <= '0;
      hist_re_q <= '0;
      hist_im_q <= '0;
      pos_gnd_q <= 1'b0;
      neg_gnd_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_COND_RE: cond_re_q <= cfg_wdata_i;
        REG_COND_IM: cond_im_q <= cfg_wdata_i;
        REG_HIST_RE: hist_re_q <= cfg_wdata_i;
        REG_HIST_IM: hist_im_q <= cfg_wdata_i;
        REG_POS_GND: pos_gnd_q <= cfg_wdata_i[0];
        REG_NEG_GND: neg_gnd_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // voltage difference, grounded ends read as zero
  assign pr = pos_gnd_q ? '0 : OPND_W'($signed(s_axis_tdata[31:0]));
  assign pi = pos_gnd_q ? '0 : OPND_W'($signed(s_axis_tdata[63:32]));
  assign nr = neg_gnd_q ? '0 : OPND_W'($signed(s_axis_tdata[95:64]));
  assign ni = neg_gnd_q ? '0 : OPND_W'($signed(s_axis_tdata[127:96]));

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dvr_q <= pr - nr;
      dvi_q <= pi - ni;
    end
  end

  // sequencer
  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    unique case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          st_d  = ST_RUN;
          cnt_d = s_axis_tuser ? STP_LAST : STP_M0;
        end
      end
      ST_RUN: begin
        if (at_last) begin
          if (slot_free) begin
            st_d  = ST_IDLE;
            cnt_d = STP_M0;
          end
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      default: begin
        st_d  = ST_IDLE;
        cnt_d = STP_M0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cnt_q <= STP_M0;
      clr_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      if (in_acc) begin
        clr_q <= s_axis_tuser;
      end
    end
  end

  // operand selection for the shared unit
  always_comb begin
    mac_op = '0;
    mac_a  = cond_re_q;
    mac_b  = dvr_q;
    if (st_q == ST_RUN) begin
      unique case (cnt_q)
        STP_M0: begin
          mac_op = '{vld: 1'b1, first: 1'b1, neg: 1'b0};
        end
        STP_M1: begin
          mac_op = '{vld: 1'b1, first: 1'b0, neg: 1'b1};
          mac_a  = cond_im_q;
          mac_b  = dvi_q;
        end
        STP_M2: begin
          mac_op = '{vld: 1'b1, first: 1'b1, neg: 1'b0};
          mac_a  = cond_im_q;
        end
        STP_M3: begin
          mac_op = '{vld: 1'b1, first: 1'b0, neg: 1'b0};
          mac_b  = dvi_q;
        end
        STP_M4: begin
          mac_op = '{vld: 1'b1, first: 1'b1, neg: 1'b0};
          mac_a  = hist_re_q;
          mac_b  = OPND_W'(cr_q);
        end
        STP_M5: begin
          mac_op = '{vld: 1'b1, first: 1'b0, neg: 1'b0};
          mac_a  = hist_im_q;
          mac_b  = OPND_W'(ci_q);
        end
        STP_M6: begin
          mac_op = '{vld: 1'b1, first: 1'b1, neg: 1'b0};
          mac_a  = hist_re_q;
          mac_b  = OPND_W'(ci_q);
        end
        STP_M7: begin
          mac_op = '{vld: 1'b1, first: 1'b0, neg: 1'b1};
          mac_a  = hist_im_q;
          mac_b  = OPND_W'(cr_q);
        end
        default: ;
      endcase
    end
  end

  ipcs_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mac_op),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  // intermediate captures
  always_ff @(posedge clk_i) begin
    if (st_q == ST_RUN) begin
      if (cnt_q == STP_M3) begin
        gdr_q <= acc;
      end
      if (cnt_q == STP_GDI) begin
        gdi_q <= acc;
        cr_q  <= sat32(gdr_q + ACC_W'(es_re_q));
        ci_q  <= sat32(acc + ACC_W'(es_im_q));
      end
      if (cnt_q == STP_M7) begin
        sr_q <= sat32(acc + gdr_q);
      end
    end
  end

  assign si = sat32(acc + gdi_q);

  // stored state doubles as the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_re_q  <= '0;
      cur_im_q  <= '0;
      es_re_q   <= '0;
      es_im_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        m_valid_q <= 1'b1;
        if (clr_q) begin
          cur_re_q <= '0;
          cur_im_q <= '0;
          es_re_q  <= '0;
          es_im_q  <= '0;
        end else begin
          cur_re_q <= cr_q;
          cur_im_q <= ci_q;
          es_re_q  <= sr_q;
          es_im_q  <= si;
        end
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {es_im_q, es_re_q, cur_im_q, cur_re_q};

  `ASSERT_CLK(a_accept_runs, in_acc |=> (st_q == ST_RUN), "accepted item did not start")
  `ASSERT_CLK(a_commit_valid, commit |=> m_axis_tvalid, "finished item not presented")
  `ASSERT_CLK(a_clear_zero, (commit && clr_q) |=> (m_axis_tdata == '0), "clear result not zero")
  `ASSERT_NEVER(a_cnt_range, (st_q == ST_RUN) && (cnt_q > STP_LAST), "step count out of range")

endmodule
